/* sv/laser_scan_to_cartesian_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the laser scan converter
// Implication checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LASER_SCAN_TO_CARTESIAN_ASSERT_SVH
`define LASER_SCAN_TO_CARTESIAN_ASSERT_SVH

// Same-cycle implication.
`define LSC_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define LSC_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/lsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants, register indexes and table for the laser scan converter.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 8'd3;

  // Fractional guard bits carried through the rotation.
  localparam int GUARD = 16;
  localparam int ROUND_HALF = 1 << (GUARD - 1);

  // 1/K of the rotation sequence in Q0.32.
  localparam logic [31:0] KINV_Q32 = 32'd2608131496;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Queue occupancy seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } lsc_qstat_t;

  // atan(2^-i) as a fraction of a turn, 2^-32 units, truncated.
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

endpackage

/* sv/lsc_intf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc interfaces
// Valid/ready channels for samples, points and register writes.
// ----------------------------------------------------------------------------
interface lsc_sample_if #(
  parameter int RANGE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] range_value;
  logic                  range_finite;
  logic                  scan_end;

  modport source (output valid, range_value, range_finite, scan_end, input ready);
  modport sink   (input valid, range_value, range_finite, scan_end, output ready);
endinterface

interface lsc_point_if #(
  parameter int RANGE_BITS = 24
);
  logic                      valid;
  logic                      ready;
  logic signed [RANGE_BITS:0] x_pos;
  logic signed [RANGE_BITS:0] y_pos;
  logic                      point_valid;
  logic                      last_point;

  modport source (output valid, x_pos, y_pos, point_valid, last_point, input ready);
  modport sink   (input valid, x_pos, y_pos, point_valid, last_point, output ready);
endinterface

interface lsc_cfg_if;
  import lsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/lsc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_front
// Holds the registers, tracks the beam angle and classifies each sample.
// ----------------------------------------------------------------------------
module lsc_front
  import lsc_pkg::*;
#(
  parameter int RANGE_BITS = 24,
  parameter int ANGLE_BITS = 32,
  parameter int DATA_W     = RANGE_BITS + ANGLE_BITS + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lsc_cfg_if.sink           cfg_i,
  lsc_sample_if.sink        sample_i,
  output logic              push_valid_o,
  output logic [DATA_W-1:0] push_data_o,
  input  logic              push_ready_i
);

  logic [RANGE_BITS-1:0] min_range_q;
  logic [RANGE_BITS-1:0] max_range_q;
  logic [ANGLE_BITS-1:0] start_angle_q;
  logic [ANGLE_BITS-1:0] angle_step_q;
  logic [ANGLE_BITS-1:0] beam_angle_q, beam_angle_d;
  logic                  at_start_q;
  logic                  in_range;
  logic                  accept;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q   <= '0;
      max_range_q   <= '1;
      start_angle_q <= '0;
      angle_step_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MIN_RANGE:   min_range_q   <= cfg_i.data[RANGE_BITS-1:0];
        REG_MAX_RANGE:   max_range_q   <= cfg_i.data[RANGE_BITS-1:0];
        REG_START_ANGLE: start_angle_q <= cfg_i.data[ANGLE_BITS-1:0];
        REG_ANGLE_STEP:  angle_step_q  <= cfg_i.data[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Restart at the start angle after a scan end, otherwise advance.
  assign beam_angle_d = at_start_q ? start_angle_q : beam_angle_q + angle_step_q;
  assign in_range = sample_i.range_finite &&
                    (sample_i.range_value >= min_range_q) &&
                    (sample_i.range_value <= max_range_q);

  assign accept         = sample_i.valid && push_ready_i;
  assign sample_i.ready = push_ready_i;
  assign push_valid_o   = sample_i.valid;
  assign push_data_o    = {sample_i.scan_end, in_range, beam_angle_d, sample_i.range_value};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_angle_q <= '0;
      at_start_q   <= 1'b1;
    end else if (accept) begin
      beam_angle_q <= beam_angle_d;
      at_start_q   <= sample_i.scan_end;
    end
  end

endmodule

/* sv/lsc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_queue
// Two-entry queue between the classifier and the rotation engine.
// ----------------------------------------------------------------------------
module lsc_queue
  import lsc_pkg::*;
#(
  parameter int DATA_W = 58
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output lsc_qstat_t        stat_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

/* sv/lsc_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_cordic
// Iterative rotation engine: scale, one micro-rotation a cycle, quadrant fix.
// ----------------------------------------------------------------------------
module lsc_cordic
  import lsc_pkg::*;
#(
  parameter int RANGE_BITS    = 24,
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 24,
  parameter int DATA_W        = RANGE_BITS + ANGLE_BITS + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  logic [DATA_W-1:0] pop_data_i,
  output logic              pop_o,
  lsc_point_if.source       point_o
);

  localparam int W  = RANGE_BITS + GUARD + 2;
  localparam int IW = $clog2(CORDIC_STAGES);
  localparam int PW = RANGE_BITS + 32;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ITER = 4'b0100,
    ST_FIN  = 4'b1000
  } lsc_state_e;

  lsc_state_e state_q, state_d;

  logic [RANGE_BITS-1:0] r_q;
  logic [1:0]            quad_q;
  logic signed [31:0]    z_q;
  logic signed [W-1:0]   x_q, y_q;
  logic [IW-1:0]         i_q;
  logic                  ok_q, last_q;

  logic [RANGE_BITS-1:0] pop_range;
  logic [ANGLE_BITS-1:0] pop_angle;
  logic                  pop_ok, pop_last;
  logic [31:0]           z_init;
  logic [PW-1:0]         prod;
  logic signed [W-1:0]   dx, dy, xr, yr;
  logic signed [31:0]    step_angle;
  logic                  out_free, load_out;

  logic signed [RANGE_BITS:0] x_pos_q, y_pos_q;
  logic                       out_valid_q, point_valid_q, last_point_q;

  function automatic logic signed [RANGE_BITS:0] finish(input logic signed [W-1:0] v);
    logic signed [W:0]            sum;
    logic signed [RANGE_BITS+2:0] sh;
    logic signed [RANGE_BITS+2:0] lim;
    sum = $signed({v[W-1], v}) + $signed((W + 1)'(ROUND_HALF));
    sh  = $signed(sum[W:GUARD]);
    lim = $signed({3'b000, {RANGE_BITS{1'b1}}});
    if (sh > lim) begin
      sh = lim;
    end else if (sh < -lim) begin
      sh = -lim;
    end
    return sh[RANGE_BITS:0];
  endfunction

  assign {pop_last, pop_ok, pop_angle, pop_range} = pop_data_i;
  assign z_init = 32'({2'b00, pop_angle[ANGLE_BITS-3:0]}) << (32 - ANGLE_BITS);

  assign prod       = PW'(r_q) * PW'(KINV_Q32);
  assign dx         = y_q >>> i_q;
  assign dy         = x_q >>> i_q;
  assign step_angle = $signed(ATAN_TURN[5'(i_q)]);

  // Undo the quadrant split.
  always_comb begin
    unique case (quad_q)
      QUAD_0: begin xr = x_q;  yr = y_q;  end
      QUAD_1: begin xr = -y_q; yr = x_q;  end
      QUAD_2: begin xr = -x_q; yr = -y_q; end
      QUAD_3: begin xr = y_q;  yr = -x_q; end
      default: begin xr = x_q; yr = y_q; end
    endcase
  end

  assign out_free = !out_valid_q || point_o.ready;
  assign load_out = (state_q == ST_FIN) && out_free;
  assign pop_o    = (state_q == ST_IDLE) && pop_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (pop_valid_i) state_d = pop_ok ? ST_MUL : ST_FIN;
      ST_MUL:  state_d = ST_ITER;
      ST_ITER: if (i_q == IW'(CORDIC_STAGES - 1)) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (point_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        r_q    <= pop_range;
        quad_q <= pop_angle[ANGLE_BITS-1 -: 2];
        z_q    <= $signed(z_init);
        ok_q   <= pop_ok;
        last_q <= pop_last;
      end
      ST_MUL: begin
        x_q <= $signed(W'(prod[PW-1:GUARD]));
        y_q <= '0;
        i_q <= '0;
      end
      ST_ITER: begin
        if (!z_q[31]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - step_angle;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + step_angle;
        end
        i_q <= i_q + IW'(1);
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      x_pos_q       <= ok_q ? finish(xr) : '0;
      y_pos_q       <= ok_q ? finish(yr) : '0;
      point_valid_q <= ok_q;
      last_point_q  <= last_q;
    end
  end

  assign point_o.valid       = out_valid_q;
  assign point_o.x_pos       = x_pos_q;
  assign point_o.y_pos       = y_pos_q;
  assign point_o.point_valid = point_valid_q;
  assign point_o.last_point  = last_point_q;

endmodule

/* sv/laser_scan_to_cartesian.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_scan_to_cartesian
// Converts laser range samples in scan order to Cartesian points.
// ----------------------------------------------------------------------------
// Each sample word on sample_i yields one point word on point_o, in order.
// Beam angles are binary fractions of a turn: the first sample after reset
// or after a scan_end sample takes start_angle, each later one adds
// angle_step. A sample that is non-finite or outside [min_range, max_range]
// gives point_valid = 0 with zero coordinates; the angle still advances.
// Valid samples are rotated by an iterative CORDIC engine that runs one
// micro-rotation per cycle; a valid point passes through dequeue, range
// scaling multiply, CORDIC_STAGES rotations, then quadrant fix and
// rounding, while an invalid one goes from dequeue straight to output. A
// two-word queue in front of the engine lets sample_i take up to two more
// samples while a point is in flight, and a held output word lets the
// engine finish the next point while the sink stalls. Registers are
// written on cfg_i (index 0 min_range, 1 max_range, 2 start_angle, 3
// angle_step; other indexes are ignored) and must only be changed while
// the block is idle. Coordinates saturate to +/-(2^RANGE_BITS - 1).
// ----------------------------------------------------------------------------
`include "laser_scan_to_cartesian_assert.svh"

module laser_scan_to_cartesian
  import lsc_pkg::*;
#(
  parameter int RANGE_BITS    = 24,
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsc_cfg_if.sink     cfg_i,
  lsc_sample_if.sink  sample_i,
  lsc_point_if.source point_o
);

  // Queue word: scan end, in-range flag, beam angle, range.
  localparam int DATA_W = RANGE_BITS + ANGLE_BITS + 2;

  logic              push_valid;
  logic [DATA_W-1:0] push_data;
  logic              pop;
  logic [DATA_W-1:0] pop_data;
  lsc_qstat_t        qstat;

  // Front: register writes, angle tracking, range check.
  lsc_front #(
    .RANGE_BITS (RANGE_BITS),
    .ANGLE_BITS (ANGLE_BITS),
    .DATA_W     (DATA_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .sample_i     (sample_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (!qstat.full)
  );

  // Decouple: hold classified samples while the engine is busy.
  lsc_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (qstat)
  );

  // Back: rotate valid samples, zero the invalid ones, drive the point word.
  lsc_cordic #(
    .RANGE_BITS    (RANGE_BITS),
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES),
    .DATA_W        (DATA_W)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (!qstat.empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .point_o     (point_o)
  );

  // Invalid points carry zero coordinates.
  `LSC_ASSERT_IMP(a_invalid_zero, point_o.valid && !point_o.point_valid,
                  point_o.x_pos == '0 && point_o.y_pos == '0, "invalid point not zeroed")

  // Saturation never lets the most negative code through.
  `LSC_ASSERT_IMP(a_sat_x, point_o.valid,
                  point_o.x_pos != {1'b1, {RANGE_BITS{1'b0}}}, "x_pos not saturated")

  // The engine only dequeues a word that is there.
  `LSC_ASSERT_IMP(a_pop_nonempty, pop, !qstat.empty, "dequeue from empty queue")

  // A dequeue from a full queue with nothing pushed leaves it no longer full.
  `LSC_ASSERT_NXT(a_queue_drain, pop && qstat.full && !push_valid, !qstat.full,
                  "queue stayed full after dequeue")

endmodule
